>>> rtl/lpar_pkg.sv
// Package for the line pixel address rasterizer.
// Holds field widths, item structs, controller state and command/status types.
// No dependencies.
`default_nettype none

package lpar_pkg;

  localparam int COORD_W      = 6;
  localparam int INK_W        = 8;
  localparam int ADDR_W       = 12;
  localparam int ROW_W        = 7;
  localparam int TILE_DIM_DEF = 64;

  localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 7'd64;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] finish_x;
    logic [COORD_W-1:0] finish_y;
    logic [INK_W-1:0]   ink;
  } lpar_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [INK_W-1:0]  pixel_ink;
    logic              final_pixel;
  } lpar_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } lpar_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch a new line command
    logic step;   // advance to the next pixel
  } lpar_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;   // current pixel is the final one
  } lpar_status_t;

endpackage

`default_nettype wire

>>> rtl/lpar_ctrl.sv
// Controller state machine of the line rasterizer.
// Depends on lpar_pkg; drives lpar_datapath through lpar_cmd_t.
`default_nettype none

module lpar_ctrl
  import lpar_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  lpar_status_t status,
  output lpar_cmd_t    cmd
);

  lpar_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DRAW;
      end
      ST_DRAW: begin
        if (out_ready && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DRAW: begin
        out_valid = 1'b1;
        cmd.step  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/lpar_datapath.sv
// Datapath of the line rasterizer: setup, error term and address stepping.
// Depends on lpar_pkg; commanded by lpar_ctrl.
`default_nettype none

module lpar_datapath
  import lpar_pkg::*;
#(
  parameter int TileDim = TILE_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [ROW_W-1:0]   cfg_wdata,
  input  lpar_in_t           in_data,
  input  lpar_cmd_t          cmd,
  output lpar_status_t       status,
  output lpar_out_t          out_data
);

  localparam int CntW = $clog2(TileDim + 1);
  localparam logic [COORD_W-1:0] CoordMax = COORD_W'(TileDim - 1);

  logic [ROW_W-1:0]   row_width;
  logic [ADDR_W-1:0]  cur_address;
  logic [COORD_W-1:0] error_term;
  logic [COORD_W-1:0] major_delta;
  logic [COORD_W-1:0] minor_delta;
  logic [ADDR_W-1:0]  major_step;
  logic [ADDR_W-1:0]  minor_step;
  logic [INK_W-1:0]   held_ink;
  logic [CntW-1:0]    pixels_left;

  // setup terms
  logic [COORD_W-1:0] x0, y0, x1, y1, dx, dy;
  logic               x_fwd, y_fwd;
  logic [ADDR_W-1:0]  x_inc, y_inc, row_inc;
  logic [ADDR_W:0]    row_base;
  logic [ADDR_W-1:0]  start_address;

  // stepping terms
  logic [COORD_W:0]   err_sum;
  logic               take_minor;
  logic [ADDR_W-1:0]  addr_major;

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] c);
    clamp = (c > CoordMax) ? CoordMax : c;
  endfunction

  always_comb begin
    x0 = clamp(in_data.start_x);
    y0 = clamp(in_data.start_y);
    x1 = clamp(in_data.finish_x);
    y1 = clamp(in_data.finish_y);
    x_fwd = (x1 >= x0);
    y_fwd = (y1 >= y0);
    dx = x_fwd ? (x1 - x0) : (x0 - x1);
    dy = y_fwd ? (y1 - y0) : (y0 - y1);
    row_inc = ADDR_W'(row_width);
    x_inc = x_fwd ? ADDR_W'(1) : '1;
    y_inc = y_fwd ? row_inc : (ADDR_W'(0) - row_inc);
    row_base = (ADDR_W + 1)'(y0) * (ADDR_W + 1)'(row_width);
    start_address = row_base[ADDR_W-1:0] + ADDR_W'(x0);
  end

  always_comb begin
    err_sum    = {1'b0, error_term} + {1'b0, minor_delta};
    take_minor = (err_sum >= {1'b0, major_delta});
    addr_major = cur_address + major_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      row_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_address <= start_address;
      held_ink    <= in_data.ink;
      if (dy > dx) begin
        major_delta <= dy;
        minor_delta <= dx;
        major_step  <= y_inc;
        minor_step  <= x_inc;
        error_term  <= dx;
        pixels_left <= CntW'(dy) + CntW'(1);
      end else begin
        major_delta <= dx;
        minor_delta <= dy;
        major_step  <= x_inc;
        minor_step  <= y_inc;
        error_term  <= dy;
        pixels_left <= CntW'(dx) + CntW'(1);
      end
    end else if (cmd.step) begin
      if (take_minor) begin
        error_term  <= COORD_W'(err_sum - {1'b0, major_delta});
        cur_address <= addr_major + minor_step;
      end else begin
        error_term  <= err_sum[COORD_W-1:0];
        cur_address <= addr_major;
      end
      pixels_left <= pixels_left - CntW'(1);
    end
  end

  assign status.last            = (pixels_left == CntW'(1));
  assign out_data.pixel_address = cur_address;
  assign out_data.pixel_ink     = held_ink;
  assign out_data.final_pixel   = status.last;

endmodule

`default_nettype wire

>>> rtl/line_pixel_address_rasterizer.sv
// Top level of the line rasterizer: Bresenham line to framebuffer writes.
// Depends on lpar_pkg, lpar_ctrl and lpar_datapath.
//
//   channel  dir   handshake              payload
//   in       in    in_valid / in_ready    in_data  (lpar_in_t, one line command)
//   out      out   out_valid / out_ready  out_data (lpar_out_t, one pixel write)
//   cfg      in    cfg_we                 cfg_wdata (row_width, 7 bits)
//
// A line of N pixels (N = major delta + 1, 1..TileDim): accepting the
// item sets up the start address (y*width + x, one small multiply) and
// the steps, then the stepping loop gives one pixel per cycle while
// out_ready is high. Synchronous reset returns the controller to idle and
// sets row_width to 64. A stall on out_ready freezes the stepping loop with
// the current pixel held on out_data; in_ready is high only while idle.
`default_nettype none

module line_pixel_address_rasterizer
  import lpar_pkg::*;
#(
  parameter int TileDim = TILE_DIM_DEF   // tile edge in pixels, 2..64
) (
  input  logic             clk,
  input  logic             rst,
  // line command items
  input  logic             in_valid,
  output logic             in_ready,
  input  lpar_in_t         in_data,
  // pixel write items
  output logic             out_valid,
  input  logic             out_ready,
  output lpar_out_t        out_data,
  // row width register
  input  logic             cfg_we,
  input  logic [ROW_W-1:0] cfg_wdata
);

  lpar_cmd_t    cmd;
  lpar_status_t status;

  // Controller: idle until a command arrives, then hold out_valid for
  // every pixel and return to idle once the final pixel is taken.
  lpar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: running address, error term and pixel count. The error term
  // starts at the minor delta; each accepted pixel adds the major step and,
  // when error + minor delta reaches the major delta, also the minor step.
  lpar_datapath #(
    .TileDim (TileDim)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
